// ===== design/dndc_pkg.sv =====
package dndc_pkg;

	localparam int AccW = 20;

	localparam logic [11:0] FIRST_YEAR   = 12'd1900;
	localparam logic [11:0] LAST_YEAR    = 12'd2099;
	localparam logic [11:0] CENTURY_20   = 12'd2000;
	localparam logic [11:0] PIVOT_YEAR   = 12'd50;
	localparam logic [11:0] TWO_DIGIT    = 12'd100;
	localparam logic [16:0] LAST_DAY_NUM = 17'd73049;
	localparam logic [8:0]  DAYS_PER_YR  = 9'd365;
	localparam logic [3:0]  MONTHS       = 4'd12;
	localparam logic [3:0]  FEB          = 4'd2;

	// ceil(2^29 / 1461): (n * RCP_1461) >> 27 is 4n / 1461, exact up to the last day number
	localparam logic [18:0] RCP_1461     = 19'd367469;

	localparam logic [1:0] ALU_ADD = 2'd0;
	localparam logic [1:0] ALU_SUB = 2'd1;
	localparam logic [1:0] ALU_MUL = 2'd2;
	localparam logic [1:0] ALU_RCP = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic       cin;
	} alu_ctl_t;

	typedef struct packed {
		logic        func;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [16:0] day_count;
	} cmd_t;

	typedef struct packed {
		logic [16:0] day_count_out;
		logic [11:0] year_out;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [2:0]  weekday;
		logic        range_error;
	} res_t;

	// days before the first of month idx + 1 in a common year
	function automatic logic [8:0] month_start(input logic [3:0] idx);
		logic [8:0] v;
		case (idx)
			4'd0: v = 9'd0;
			4'd1: v = 9'd31;
			4'd2: v = 9'd59;
			4'd3: v = 9'd90;
			4'd4: v = 9'd120;
			4'd5: v = 9'd151;
			4'd6: v = 9'd181;
			4'd7: v = 9'd212;
			4'd8: v = 9'd243;
			4'd9: v = 9'd273;
			4'd10: v = 9'd304;
			4'd11: v = 9'd334;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	function automatic logic [8:0] month_start_plus(input logic [3:0] idx, input logic add);
		return month_start(idx) + {8'd0, add};
	endfunction

endpackage

// ===== design/day_number_date_converter.sv =====
// Converts between a calendar date and a day number counted from 1 January 1900 (day 0),
// for 1900 through 2099, with every fourth year a leap year. One shared add/subtract/
// multiply unit is stepped by a small sequencer, and cmd_stall stays high while an
// item is in work. A date-to-number word steps through the multiply, base, month-start
// and day states; a number-to-date word runs a reciprocal multiply for the divide by 1461
// that gives the year, then a month search that tests one month per step, one to twelve.
// Out-of-range words go from the check state straight to the done state. A finished
// result waits in an output register, so the next word can be accepted while res_valid
// is still stalled.
module day_number_date_converter (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  dndc_pkg::cmd_t   cmd,
	output logic             res_valid,
	input  logic             res_stall,
	output dndc_pkg::res_t   res
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CHK  = 4'd1;
	localparam logic [3:0] ST_DIV  = 4'd2;
	localparam logic [3:0] ST_MUL  = 4'd3;
	localparam logic [3:0] ST_BASE = 4'd4;
	localparam logic [3:0] ST_DMS  = 4'd5;
	localparam logic [3:0] ST_DDAY = 4'd6;
	localparam logic [3:0] ST_NSUB = 4'd7;
	localparam logic [3:0] ST_INC  = 4'd8;
	localparam logic [3:0] ST_LEAP = 4'd9;
	localparam logic [3:0] ST_MON  = 4'd10;
	localparam logic [3:0] ST_DAY  = 4'd11;
	localparam logic [3:0] ST_DONE = 4'd12;

	logic [3:0]                state_q;
	logic                      res_valid_q;
	dndc_pkg::res_t            res_q;
	dndc_pkg::cmd_t            cmd_q;
	logic [dndc_pkg::AccW-1:0] acc_q;
	logic [7:0]                sh_q;
	logic [3:0]                m_q;
	logic                      leap_q;
	logic                      err_q;
	logic [2:0]                wd_q;

	dndc_pkg::alu_ctl_t        alu_ctl;
	logic [dndc_pkg::AccW-1:0] alu_a;
	logic [dndc_pkg::AccW-1:0] alu_b;
	logic [dndc_pkg::AccW-1:0] alu_sum;
	logic                      alu_neg;

	logic [11:0]               full_year;
	logic                      d_err;
	logic                      n_err;
	logic [7:0]                yoff;
	logic [6:0]                base_inc;
	logic [8:0]                base_tmp;
	logic                      leap_d;
	logic [5:0]                oct_sum;
	logic [3:0]                fold;
	logic [2:0]                wd_d;
	logic                      out_free;
	logic                      mon_more;
	dndc_pkg::res_t            res_d;

	dndc_alu u_alu (
		.ctl (alu_ctl),
		.a   (alu_a),
		.b   (alu_b),
		.sum (alu_sum)
	);

	assign alu_neg  = alu_sum[dndc_pkg::AccW-1];
	assign out_free = !res_valid_q || !res_stall;
	assign mon_more = (m_q < dndc_pkg::MONTHS) && !alu_neg;

	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// two-digit year expansion and range checks
	always_comb begin
		if (cmd_q.year < dndc_pkg::PIVOT_YEAR) begin
			full_year = cmd_q.year + dndc_pkg::CENTURY_20;
		end else if (cmd_q.year < dndc_pkg::TWO_DIGIT) begin
			full_year = cmd_q.year + dndc_pkg::FIRST_YEAR;
		end else begin
			full_year = cmd_q.year;
		end
		d_err = (full_year < dndc_pkg::FIRST_YEAR) || (full_year > dndc_pkg::LAST_YEAR) ||
			(cmd_q.month < 4'd1) || (cmd_q.month > dndc_pkg::MONTHS) || (cmd_q.day == 5'd0);
		n_err = cmd_q.day_count > dndc_pkg::LAST_DAY_NUM;
		yoff  = 8'(full_year - dndc_pkg::FIRST_YEAR);
	end

	// weekday: octal digits summed, since 8 is 1 mod 7
	always_comb begin
		oct_sum = 6'(cmd_q.day_count[2:0]) + 6'(cmd_q.day_count[5:3]) +
			6'(cmd_q.day_count[8:6]) + 6'(cmd_q.day_count[11:9]) +
			6'(cmd_q.day_count[14:12]) + 6'(cmd_q.day_count[16:15]);
		fold = 4'(oct_sum[5:3]) + 4'(oct_sum[2:0]);
		if (fold >= 4'd7) begin
			wd_d = 3'(fold - 4'd7);
		end else begin
			wd_d = fold[2:0];
		end
	end

	assign base_tmp = {1'b0, sh_q} + 9'd3;
	assign base_inc = base_tmp[8:2];
	assign leap_d   = (sh_q[1:0] == 2'b00) && (cmd_q.month > dndc_pkg::FEB);

	// operand select for the shared unit
	always_comb begin
		alu_ctl.op  = dndc_pkg::ALU_ADD;
		alu_ctl.cin = 1'b0;
		alu_a       = acc_q;
		alu_b       = '0;
		case (state_q)
			ST_DIV: begin
				alu_ctl.op = dndc_pkg::ALU_RCP;
				alu_a      = {3'd0, cmd_q.day_count};
			end
			ST_MUL: begin
				alu_ctl.op = dndc_pkg::ALU_MUL;
				alu_a      = {12'd0, sh_q};
			end
			ST_BASE: begin
				alu_b = {13'd0, base_inc};
			end
			ST_DMS: begin
				alu_b = {11'd0, dndc_pkg::month_start_plus(4'(cmd_q.month - 4'd1), leap_d)};
			end
			ST_DDAY: begin
				alu_b = {15'd0, 5'(cmd_q.day - 5'd1)};
			end
			ST_NSUB: begin
				alu_ctl.op  = dndc_pkg::ALU_SUB;
				alu_ctl.cin = 1'b1;
				alu_a       = {3'd0, cmd_q.day_count};
				alu_b       = acc_q;
			end
			ST_INC: begin
				alu_ctl.cin = 1'b1;
			end
			ST_LEAP: begin
				alu_ctl.op = dndc_pkg::ALU_SUB;
				alu_b      = {11'd0, dndc_pkg::month_start(dndc_pkg::FEB)};
			end
			ST_MON: begin
				alu_ctl.op = dndc_pkg::ALU_SUB;
				alu_b      = {11'd0, dndc_pkg::month_start_plus(m_q, leap_q)};
			end
			ST_DAY: begin
				alu_ctl.op  = dndc_pkg::ALU_SUB;
				alu_ctl.cin = 1'b1;
				alu_b       = {11'd0, dndc_pkg::month_start_plus(4'(m_q - 4'd1),
					leap_q && (m_q > dndc_pkg::FEB))};
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	always_comb begin
		res_d = '0;
		if (err_q) begin
			res_d.range_error = 1'b1;
		end else if (!cmd_q.func) begin
			res_d.day_count_out = acc_q[16:0];
		end else begin
			res_d.year_out  = {4'd0, sh_q} + dndc_pkg::FIRST_YEAR;
			res_d.month_out = m_q;
			res_d.day_out   = acc_q[4:0];
			res_d.weekday   = wd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (cmd_q.func ? n_err : d_err) begin
						state_q <= ST_DONE;
					end else if (cmd_q.func) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_DIV: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_BASE;
				ST_BASE: state_q <= cmd_q.func ? ST_NSUB : ST_DMS;
				ST_DMS: state_q <= ST_DDAY;
				ST_DDAY: state_q <= ST_DONE;
				ST_NSUB: state_q <= ST_INC;
				ST_INC: state_q <= ST_LEAP;
				ST_LEAP: state_q <= ST_MON;
				ST_MON: begin
					if (!mon_more) begin
						state_q <= ST_DAY;
					end
				end
				ST_DAY: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_q <= cmd;
				end
			end
			ST_CHK: begin
				err_q <= cmd_q.func ? n_err : d_err;
				sh_q  <= yoff;
				wd_q  <= wd_d;
			end
			ST_DIV: begin
				sh_q <= alu_sum[7:0];
			end
			ST_LEAP: begin
				leap_q <= (sh_q[1:0] == 2'b00) && !alu_neg;
				m_q    <= 4'd1;
			end
			ST_MON: begin
				if (mon_more) begin
					m_q <= m_q + 4'd1;
				end
			end
			ST_MUL, ST_BASE, ST_DMS, ST_DDAY, ST_NSUB, ST_INC, ST_DAY: begin
				acc_q <= alu_sum;
			end
			ST_DONE: begin
				if (out_free) begin
					res_q <= res_d;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.range_error |-> res.day_count_out == 17'd0 &&
		res.year_out == 12'd0 && res.month_out == 4'd0 && res.day_out == 5'd0 &&
		res.weekday == 3'd0)
		else $error("error word carries nonzero fields");

	a_date_sane: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.range_error && res.year_out != 12'd0 |->
		res.month_out >= 4'd1 && res.month_out <= 4'd12 && res.day_out != 5'd0 &&
		res.weekday <= 3'd6 && res.day_count_out == 17'd0)
		else $error("converted date out of range");

	a_year_off: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> {4'd0, sh_q} <= dndc_pkg::LAST_YEAR - dndc_pkg::FIRST_YEAR)
		else $error("year offset out of range");

	a_month_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MON |-> m_q >= 4'd1 && m_q <= dndc_pkg::MONTHS)
		else $error("month search index out of range");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall && state_q == ST_CHK)
		else $error("accepted word did not start the sequencer");
`endif

endmodule

// ===== design/dndc_alu.sv =====
module dndc_alu (
	input  dndc_pkg::alu_ctl_t            ctl,
	input  logic [dndc_pkg::AccW-1:0]     a,
	input  logic [dndc_pkg::AccW-1:0]     b,
	output logic [dndc_pkg::AccW-1:0]     sum
);

	logic [16:0] prod;
	logic [35:0] rcp_prod;

	assign prod     = a[7:0] * dndc_pkg::DAYS_PER_YR;
	assign rcp_prod = a[16:0] * dndc_pkg::RCP_1461;

	always_comb begin
		case (ctl.op)
			dndc_pkg::ALU_ADD: sum = a + b + {{(dndc_pkg::AccW-1){1'b0}}, ctl.cin};
			dndc_pkg::ALU_SUB: sum = a + ~b + {{(dndc_pkg::AccW-1){1'b0}}, ctl.cin};
			dndc_pkg::ALU_MUL: sum = {{(dndc_pkg::AccW-17){1'b0}}, prod};
			dndc_pkg::ALU_RCP: sum = {{(dndc_pkg::AccW-9){1'b0}}, rcp_prod[35:27]};
			default: sum = a;
		endcase
	end

endmodule

// ===== tb/day_number_date_converter_tb.sv =====
`timescale 1ns / 1ps

module day_number_date_converter_tb;

	localparam logic FN_DATE_TO_NUM = 1'b0;
	localparam logic FN_NUM_TO_DATE = 1'b1;

	localparam int unsigned BASE_YEAR   = 1900;
	localparam int unsigned TOP_YEAR    = 2099;
	localparam int unsigned TOP_DAY_NUM = 73049;
	localparam int unsigned DAYS_BEFORE_MONTH [12] =
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	localparam int NUM_RANDOM   = 1700;
	localparam int QUIET_TAIL   = 150;
	localparam int HOLD_CYCLES  = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	dndc_pkg::cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	dndc_pkg::res_t res;

	dndc_pkg::cmd_t date_requests[$];
	dndc_pkg::res_t predicted_results[$];

	logic hold_req = 1'b0;
	int fail_count = 0;
	int words_sent = 0;
	int date_words = 0;
	int number_words = 0;
	int range_words = 0;
	int results_seen = 0;

	int gap_left = 0;
	int stall_left = 0;
	bit send_idle_on = 1'b1;
	bit recv_idle_on = 1'b1;
	bit next_stall;
	dndc_pkg::res_t want;

	day_number_date_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// days from 1 january 1900 to 1 january of the given year offset
	function automatic int unsigned days_to_year(input int unsigned y);
		return 365 * y + (y + 3) / 4;
	endfunction

	function automatic dndc_pkg::res_t convert_calendar(input dndc_pkg::cmd_t c);
		dndc_pkg::res_t r;
		int unsigned yr, y, n, doy, leap, m;
		r = '0;
		if (c.func == FN_DATE_TO_NUM) begin
			yr = 32'(c.year);
			if (yr < 50)
				yr += 2000;
			else if (yr < 100)
				yr += 1900;
			if (yr < BASE_YEAR || yr > TOP_YEAR || c.month < 1 || c.month > 12 || c.day == 0) begin
				r.range_error = 1'b1;
			end else begin
				y = yr - BASE_YEAR;
				n = days_to_year(y) + DAYS_BEFORE_MONTH[int'(c.month) - 1] + c.day - 1;
				if (yr % 4 == 0 && c.month > 2)
					n++;
				r.day_count_out = n[16:0];
			end
		end else begin
			n = 32'(c.day_count);
			if (n > TOP_DAY_NUM) begin
				r.range_error = 1'b1;
			end else begin
				y = (4 * n) / 1461;
				doy = n - days_to_year(y) + 1;
				leap = (y % 4 == 0 && doy > DAYS_BEFORE_MONTH[2]) ? 1 : 0;
				m = 1;
				while (m < 12 && doy > DAYS_BEFORE_MONTH[m] + leap)
					m++;
				doy -= DAYS_BEFORE_MONTH[m - 1];
				if (m > 2)
					doy -= leap;
				r.year_out = 12'(y + BASE_YEAR);
				r.month_out = 4'(m);
				r.day_out = 5'(doy);
				r.weekday = 3'(n % 7);
			end
		end
		return r;
	endfunction

	function automatic dndc_pkg::cmd_t make_word(input logic f, input int unsigned yr,
			input int unsigned mo, input int unsigned dy, input int unsigned cnt);
		dndc_pkg::cmd_t c;
		c.func = f;
		c.year = 12'(yr);
		c.month = 4'(mo);
		c.day = 5'(dy);
		c.day_count = 17'(cnt);
		return c;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned got_v);
		if (exp_v != got_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!cmd_valid || !cmd_stall) begin
				if (cmd_valid) begin
					predicted_results.push_back(convert_calendar(cmd));
					words_sent++;
					if (cmd.func == FN_DATE_TO_NUM)
						date_words++;
					else
						number_words++;
					if (predicted_results[$].range_error)
						range_words++;
					if (words_sent % 64 == 0)
						send_idle_on = ($urandom_range(0, 3) != 0);
				end
				if (gap_left > 0) begin
					gap_left--;
					cmd_valid <= 1'b0;
				end else if (date_requests.size() > 0) begin
					cmd <= date_requests.pop_front();
					cmd_valid <= 1'b1;
					if (send_idle_on && date_requests.size() > QUIET_TAIL
							&& $urandom_range(0, 99) < 20)
						gap_left = $urandom_range(1, 17);
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (predicted_results.size() == 0) begin
					$error("result word arrived with nothing expected");
					fail_count++;
				end else begin
					want = predicted_results.pop_front();
					check_field("day_count_out", 32'(want.day_count_out),
						32'(res.day_count_out));
					check_field("year_out", 32'(want.year_out), 32'(res.year_out));
					check_field("month_out", 32'(want.month_out), 32'(res.month_out));
					check_field("day_out", 32'(want.day_out), 32'(res.day_out));
					check_field("weekday", 32'(want.weekday), 32'(res.weekday));
					check_field("range_error", 32'(want.range_error), 32'(res.range_error));
				end
				results_seen++;
				if (results_seen % 50 == 0)
					recv_idle_on = ($urandom_range(0, 3) != 0);
			end
			next_stall = 1'b0;
			if (stall_left > 0) begin
				stall_left--;
				next_stall = 1'b1;
			end else if (recv_idle_on && date_requests.size() > QUIET_TAIL
					&& $urandom_range(0, 99) < 20) begin
				stall_left = $urandom_range(1, 17) - 1;
				next_stall = 1'b1;
			end
			res_stall <= next_stall || hold_req;
		end
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		while (words_sent < 400)
			@(posedge clk);
		hold_req <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_req <= 1'b0;
	end

	initial begin
		#10_000_000;
		$display("** day_number_date_converter: FAILED **");
		$finish;
	end

	initial begin
		dndc_pkg::cmd_t c;
		int sel;

		// two-digit years and the century edges
		date_requests.push_back(make_word(FN_DATE_TO_NUM, 0, 1, 1, 131071));
		date_requests.push_back(make_word(FN_DATE_TO_NUM, 49, 12, 31, 0));
		date_requests.push_back(make_word(FN_DATE_TO_NUM, 50, 1, 1, 0));
		date_requests.push_back(make_word(FN_DATE_TO_NUM, 99, 12, 31, 0));
		date_requests.push_back(make_word(FN_DATE_TO_NUM, 1900, 1, 1, 0));
		date_requests.push_back(make_word(FN_DATE_TO_NUM, 2099, 12, 31, 0));
		// out of range dates
		date_requests.push_back(make_word(FN_DATE_TO_NUM, 100, 6, 15, 0));
		date_requests.push_back(make_word(FN_DATE_TO_NUM, 1899, 12, 31, 0));
		date_requests.push_back(make_word(FN_DATE_TO_NUM, 2100, 1, 1, 0));
		date_requests.push_back(make_word(FN_DATE_TO_NUM, 4095, 15, 31, 0));
		date_requests.push_back(make_word(FN_DATE_TO_NUM, 2000, 0, 1, 0));
		date_requests.push_back(make_word(FN_DATE_TO_NUM, 2000, 13, 1, 0));
		date_requests.push_back(make_word(FN_DATE_TO_NUM, 2000, 5, 0, 0));
		// leap handling and day past month end
		date_requests.push_back(make_word(FN_DATE_TO_NUM, 1900, 3, 1, 0));
		date_requests.push_back(make_word(FN_DATE_TO_NUM, 2000, 2, 29, 0));
		date_requests.push_back(make_word(FN_DATE_TO_NUM, 1901, 2, 31, 0));
		// number to date edges
		date_requests.push_back(make_word(FN_NUM_TO_DATE, 4095, 15, 31, 0));
		date_requests.push_back(make_word(FN_NUM_TO_DATE, 0, 0, 0, 59));
		date_requests.push_back(make_word(FN_NUM_TO_DATE, 0, 0, 0, 60));
		date_requests.push_back(make_word(FN_NUM_TO_DATE, 0, 0, 0, 365));
		date_requests.push_back(make_word(FN_NUM_TO_DATE, 0, 0, 0, 366));
		date_requests.push_back(make_word(FN_NUM_TO_DATE, 0, 0, 0, 1461));
		date_requests.push_back(make_word(FN_NUM_TO_DATE, 0, 0, 0, 73049));
		date_requests.push_back(make_word(FN_NUM_TO_DATE, 0, 0, 0, 73050));
		date_requests.push_back(make_word(FN_NUM_TO_DATE, 0, 0, 0, 131071));

		for (int i = 0; i < NUM_RANDOM; i++) begin
			sel = $urandom_range(0, 99);
			c = make_word(1'($urandom_range(0, 1)), $urandom_range(0, 4095),
				$urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 131071));
			if (sel < 45) begin
				c.func = FN_DATE_TO_NUM;
				c.year = $urandom_range(0, 1) ? 12'($urandom_range(1900, 2099))
					: 12'($urandom_range(0, 99));
				c.month = 4'($urandom_range(1, 12));
				c.day = 5'($urandom_range(1, 31));
			end else if (sel < 85) begin
				c.func = FN_NUM_TO_DATE;
				c.day_count = 17'($urandom_range(0, TOP_DAY_NUM));
			end
			date_requests.push_back(c);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (date_requests.size() > 0 || cmd_valid || predicted_results.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("run covered %0d words (%0d date to number, %0d number to date)",
			words_sent, date_words, number_words);
		$display("%0d words out of range, %0d results checked, %0d mismatches",
			range_words, results_seen, fail_count);
		if (fail_count == 0)
			$display("** day_number_date_converter: PASSED **");
		else
			$display("** day_number_date_converter: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
design/dndc_pkg.sv
design/dndc_alu.sv
design/day_number_date_converter.sv
tb/day_number_date_converter_tb.sv
